// File: hdl/smoothed_speed_estimator_defines.svh
// ----------------------------------------------------------------------------
// smoothed_speed_estimator_defines
// assertion macros shared by the speed estimator rtl
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_SPEED_ESTIMATOR_DEFINES_SVH
`define SMOOTHED_SPEED_ESTIMATOR_DEFINES_SVH

// condition implies expression in the same cycle
`define SSE_CHECK_NOW(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// condition implies expression in the next cycle
`define SSE_CHECK_NEXT(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: hdl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// shared widths, constants and word types of the smoothed speed estimator
// ----------------------------------------------------------------------------
package sse_pkg;

   // field widths
   localparam int POS_W      = 24;
   localparam int TIME_W     = 20;
   localparam int SPEED_W    = 32;
   localparam int NORM_W     = 17;
   localparam int NORM_FRAC_W = 16;
   localparam int WLEN_W     = 5;

   // csr port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED     = 1'b1;

   // reset values of the csr registers
   localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RESET = 5'd10;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET     = 32'd256000;
   localparam int DEFAULT_MAX_WINDOW = 16;

   // datapath widths
   localparam int DIFF_W  = POS_W + 1;
   localparam int D2_W    = 2 * DIFF_W;
   localparam int ROOT_W  = DIFF_W;
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;
   localparam int NUM_W   = ROOT_W + SCALE_W;

   // serial divider
   localparam int DIV_W      = 32;
   localparam int DIV_STEP_W = 6;

   localparam logic [NORM_W-1:0] NORM_ONE = 17'h10000;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [TIME_W-1:0]       elapsed_us;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] smooth_speed;
      logic [NORM_W-1:0]  normalized_speed;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_cmd_type;

endpackage

// File: hdl/sse_sqrt.sv
// ----------------------------------------------------------------------------
// sse_sqrt
// digit-serial integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module sse_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sse_pkg::D2_W-1:0]      radicand,
   output logic                          done,
   output logic [sse_pkg::ROOT_W-1:0]    root
);

   localparam int D2_W    = sse_pkg::D2_W;
   localparam int ROOT_W  = sse_pkg::ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int STEP_W  = $clog2(ROOT_W);

   logic [D2_W-1:0]   v_ff, v_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;

   // one result bit per step
   always_comb begin
      rem_sh  = {rem_ff, v_ff[D2_W-1:D2_W-2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      diff    = rem_sh - trial;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[D2_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: hdl/sse_div.sv
// ----------------------------------------------------------------------------
// sse_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sse_div (
   input  logic                          clock,
   input  logic                          reset,
   input  sse_pkg::div_cmd_type          cmd,
   input  logic [sse_pkg::DIV_W-1:0]     rem_init,
   input  logic [sse_pkg::DIV_W-1:0]     divisor,
   input  logic [sse_pkg::DIV_W-1:0]     dividend_bits,
   output logic                          done,
   output logic [sse_pkg::DIV_W-1:0]     quotient
);

   localparam int DIV_W  = sse_pkg::DIV_W;
   localparam int STEP_W = sse_pkg::DIV_STEP_W;

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DIV_W-1:0]  bits_ff, bits_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    trial;
   logic              fits;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, bits_ff[DIV_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = rem_init;
         den_in  = divisor;
         bits_in = dividend_bits;
         quot_in = '0;
         step_in = cmd.steps - STEP_W'(1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bits_in = {bits_ff[DIV_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_W-2:0], fits};
         rem_in  = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: hdl/smoothed_speed_estimator.sv
// ----------------------------------------------------------------------------
// smoothed_speed_estimator
// 3d speed from successive positions, averaged over a sliding window
//
//   channel   ports                              word
//   request   req_valid / req_ready / req_data   position and elapsed time
//   response  rsp_valid / rsp_ready / rsp_data   window average, normalized
//   csr       csr_we / csr_index / csr_wdata     window_length, max_speed
//
// one word at a time: the next word can be accepted once the result is registered;
// the first word after reset skips the squarer, the root and the speed and last
// divisions (no distance, zero average). a zero or saturated speed skips the speed
// division, a zero average or a ratio of two or more to max_speed skips the last one
// the work is done by the serial square root (25 steps) and three passes
// through the shared bit-serial divider (32, 32 and 17 steps)
// synchronous reset clears the window and the position history and resets the csrs
// a held result in the output register does not stop the next word from
// being accepted; the block only waits at the end if it is still unread
// ----------------------------------------------------------------------------
`include "smoothed_speed_estimator_defines.svh"

module smoothed_speed_estimator #(
   parameter int MAX_WINDOW = sse_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sse_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sse_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sse_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int POS_W   = sse_pkg::POS_W;
   localparam int TIME_W  = sse_pkg::TIME_W;
   localparam int SPEED_W = sse_pkg::SPEED_W;
   localparam int NORM_W  = sse_pkg::NORM_W;
   localparam int WLEN_W  = sse_pkg::WLEN_W;
   localparam int DIFF_W  = sse_pkg::DIFF_W;
   localparam int D2_W    = sse_pkg::D2_W;
   localparam int ROOT_W  = sse_pkg::ROOT_W;
   localparam int NUM_W   = sse_pkg::NUM_W;
   localparam int DIV_W   = sse_pkg::DIV_W;
   localparam int STEP_W  = sse_pkg::DIV_STEP_W;
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W   = SPEED_W + CNT_W;

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SQUARE    = 4'd1;
   localparam logic [3:0] S_ROOT_GO   = 4'd2;
   localparam logic [3:0] S_ROOT_WAIT = 4'd3;
   localparam logic [3:0] S_SCALE     = 4'd4;
   localparam logic [3:0] S_RAW_GO    = 4'd5;
   localparam logic [3:0] S_RAW_WAIT  = 4'd6;
   localparam logic [3:0] S_READ      = 4'd7;
   localparam logic [3:0] S_UPDATE    = 4'd8;
   localparam logic [3:0] S_AVG_GO    = 4'd9;
   localparam logic [3:0] S_AVG_WAIT  = 4'd10;
   localparam logic [3:0] S_NORM_GO   = 4'd11;
   localparam logic [3:0] S_NORM_WAIT = 4'd12;
   localparam logic [3:0] S_FINISH    = 4'd13;

   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   // magnitude of the difference of two positions
   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                   input logic signed [POS_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   logic [3:0]                state_ff, state_in;
   logic [WLEN_W-1:0]         wlen_ff, wlen_in;
   logic [SPEED_W-1:0]        max_speed_ff, max_speed_in;
   logic signed [POS_W-1:0]   last_x_ff, last_x_in;
   logic signed [POS_W-1:0]   last_y_ff, last_y_in;
   logic signed [POS_W-1:0]   last_z_ff, last_z_in;
   logic                      have_last_ff, have_last_in;
   logic [DIFF_W-1:0]         ax_ff, ax_in;
   logic [DIFF_W-1:0]         ay_ff, ay_in;
   logic [DIFF_W-1:0]         az_ff, az_in;
   logic [TIME_W-1:0]         elapsed_ff, elapsed_in;
   logic [1:0]                axis_ff, axis_in;
   logic [D2_W-1:0]           d2_ff, d2_in;
   logic [ROOT_W-1:0]         dist_ff, dist_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [SPEED_W-1:0]        raw_ff, raw_in;
   logic [SPEED_W-1:0]        avg_ff, avg_in;
   logic [NORM_W-1:0]         norm_ff, norm_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sse_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic [SPEED_W-1:0]        old_ff;
   logic [SPEED_W-1:0]        hist_mem [0:MAX_WINDOW-1];

   logic [DIFF_W-1:0]         sq_op;
   logic [D2_W-1:0]           sq_prod;
   logic [NUM_W-1:0]          scaled;
   logic [CNT_W-1:0]          len;
   logic [SLOT_W-1:0]         slot_eff;
   logic [CNT_W-1:0]          slot_plus;
   logic                      raw_needs_div;
   logic                      norm_needs_div;
   logic [NORM_W-1:0]         norm_q;
   logic                      accept;
   logic                      div_wait;
   logic                      norm_in_range;

   logic                      sqrt_start;
   logic                      sqrt_done;
   logic [ROOT_W-1:0]         sqrt_root;
   sse_pkg::div_cmd_type      div_cmd;
   logic [DIV_W-1:0]          div_rem_init;
   logic [DIV_W-1:0]          div_divisor;
   logic [DIV_W-1:0]          div_bits;
   logic                      div_done;
   logic [DIV_W-1:0]          div_quot;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared squarer, one axis per cycle
   assign sq_op   = (axis_ff == AXIS_X) ? ax_ff : ((axis_ff == AXIS_Y) ? ay_ff : az_ff);
   assign sq_prod = sq_op * sq_op;
   assign scaled  = NUM_W'(dist_ff) * NUM_W'(sse_pkg::US_PER_S);

   // effective window length, slot and wrap
   always_comb begin
      if (wlen_ff == '0) begin
         len = CNT_W'(1);
      end else if (int'(wlen_ff) > MAX_WINDOW) begin
         len = CNT_W'(MAX_WINDOW);
      end else begin
         len = CNT_W'(wlen_ff);
      end
      slot_eff  = (CNT_W'(slot_ff) >= len) ? '0 : slot_ff;
      slot_plus = CNT_W'(slot_ff) + CNT_W'(1);
   end

   // saturation and corner checks ahead of the divider
   assign raw_needs_div  = (dist_ff != '0) &&
                           (TIME_W'(num_ff[NUM_W-1:DIV_W]) < elapsed_ff);
   assign norm_needs_div = (avg_ff != '0) &&
                           ({1'b0, avg_ff} < {max_speed_ff, 1'b0});
   assign norm_q         = div_quot[NORM_W-1:0];

   // divider operand select
   always_comb begin
      div_cmd      = '0;
      div_rem_init = '0;
      div_divisor  = '0;
      div_bits     = '0;
      case (state_ff)
         S_RAW_GO: begin
            div_rem_init  = DIV_W'(num_ff[NUM_W-1:DIV_W]);
            div_divisor   = DIV_W'(elapsed_ff);
            div_bits      = num_ff[DIV_W-1:0];
            div_cmd.steps = STEP_W'(DIV_W);
            div_cmd.start = raw_needs_div;
         end
         S_AVG_GO: begin
            div_rem_init  = DIV_W'(sum_ff[SUM_W-1:SPEED_W]);
            div_divisor   = DIV_W'(count_ff);
            div_bits      = sum_ff[DIV_W-1:0];
            div_cmd.steps = STEP_W'(DIV_W);
            div_cmd.start = 1'b1;
         end
         S_NORM_GO: begin
            div_rem_init  = {1'b0, avg_ff[SPEED_W-1:1]};
            div_divisor   = max_speed_ff;
            div_bits      = {avg_ff[0], (DIV_W-1)'(0)};
            div_cmd.steps = STEP_W'(NORM_W);
            div_cmd.start = norm_needs_div;
         end
         default: begin
         end
      endcase
   end

   assign sqrt_start = (state_ff == S_ROOT_GO);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      max_speed_in = max_speed_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      last_z_in    = last_z_ff;
      have_last_in = have_last_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      elapsed_in   = elapsed_ff;
      axis_in      = axis_ff;
      d2_in        = d2_ff;
      dist_in      = dist_ff;
      num_in       = num_ff;
      raw_in       = raw_ff;
      avg_in       = avg_ff;
      norm_in      = norm_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ax_in        = abs_diff(req_data.pos_x, last_x_ff);
               ay_in        = abs_diff(req_data.pos_y, last_y_ff);
               az_in        = abs_diff(req_data.pos_z, last_z_ff);
               elapsed_in   = req_data.elapsed_us;
               last_x_in    = req_data.pos_x;
               last_y_in    = req_data.pos_y;
               last_z_in    = req_data.pos_z;
               have_last_in = 1'b1;
               axis_in      = AXIS_X;
               d2_in        = '0;
               if (have_last_ff) begin
                  state_in = S_SQUARE;
               end else begin
                  raw_in   = '0;
                  state_in = S_READ;
               end
            end
         end
         S_SQUARE: begin
            d2_in   = d2_ff + sq_prod;
            axis_in = axis_ff + 2'd1;
            if (axis_ff == AXIS_LAST) begin
               state_in = S_ROOT_GO;
            end
         end
         S_ROOT_GO: begin
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (sqrt_done) begin
               dist_in  = sqrt_root;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            num_in   = scaled;
            state_in = S_RAW_GO;
         end
         S_RAW_GO: begin
            if (dist_ff == '0) begin
               raw_in   = '0;
               state_in = S_READ;
            end else if (!raw_needs_div) begin
               raw_in   = '1;
               state_in = S_READ;
            end else begin
               state_in = S_RAW_WAIT;
            end
         end
         S_RAW_WAIT: begin
            if (div_done) begin
               raw_in   = div_quot;
               state_in = S_READ;
            end
         end
         S_READ: begin
            slot_in  = slot_eff;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (count_ff < len) begin
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + SUM_W'(raw_ff);
            end else begin
               sum_in   = sum_ff - SUM_W'(old_ff) + SUM_W'(raw_ff);
            end
            slot_in  = (slot_plus >= len) ? '0 : SLOT_W'(slot_plus);
            state_in = S_AVG_GO;
         end
         S_AVG_GO: begin
            state_in = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (div_done) begin
               avg_in   = div_quot;
               state_in = S_NORM_GO;
            end
         end
         S_NORM_GO: begin
            if (avg_ff == '0) begin
               norm_in  = '0;
               state_in = S_FINISH;
            end else if (!norm_needs_div) begin
               norm_in  = sse_pkg::NORM_ONE;
               state_in = S_FINISH;
            end else begin
               state_in = S_NORM_WAIT;
            end
         end
         S_NORM_WAIT: begin
            if (div_done) begin
               norm_in  = (norm_q > sse_pkg::NORM_ONE) ? sse_pkg::NORM_ONE : norm_q;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.smooth_speed     = avg_ff;
               rsp_data_in.normalized_speed = norm_ff;
               rsp_valid_in                 = 1'b1;
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // csr writes, the user must make them only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            sse_pkg::REG_WINDOW_LENGTH: begin
               wlen_in  = csr_wdata[WLEN_W-1:0];
               slot_in  = '0;
               count_in = '0;
               sum_in   = '0;
            end
            sse_pkg::REG_MAX_SPEED: begin
               max_speed_in = csr_wdata[SPEED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wlen_ff      <= sse_pkg::WINDOW_LENGTH_RESET;
         max_speed_ff <= sse_pkg::MAX_SPEED_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_z_ff    <= '0;
         have_last_ff <= 1'b0;
         slot_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= AXIS_X;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         max_speed_ff <= max_speed_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         last_z_ff    <= last_z_in;
         have_last_ff <= have_last_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      elapsed_ff  <= elapsed_in;
      d2_ff       <= d2_in;
      dist_ff     <= dist_in;
      num_ff      <= num_in;
      raw_ff      <= raw_in;
      avg_ff      <= avg_in;
      norm_ff     <= norm_in;
      rsp_data_ff <= rsp_data_in;
   end

   // speed history, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         hist_mem[slot_ff] <= raw_ff;
      end
      if (state_ff == S_READ) begin
         old_ff <= hist_mem[slot_eff];
      end
   end

   sse_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (d2_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   sse_div u_div (
      .clock         (clock),
      .reset         (reset),
      .cmd           (div_cmd),
      .rem_init      (div_rem_init),
      .divisor       (div_divisor),
      .dividend_bits (div_bits),
      .done          (div_done),
      .quotient      (div_quot)
   );

   // terms for the checks
   assign div_wait      = (state_ff == S_RAW_WAIT) || (state_ff == S_AVG_WAIT) ||
                          (state_ff == S_NORM_WAIT);
   assign norm_in_range = (rsp_data.normalized_speed <= sse_pkg::NORM_ONE);

   // checks
   `SSE_CHECK_NEXT(a_accept_leaves_idle, accept, !req_ready, "accepted word did not start work")
   `SSE_CHECK_NOW(a_count_in_window, 1'b1, count_ff <= len, "sample count beyond window length")
   `SSE_CHECK_NOW(a_div_done_in_wait, div_done, div_wait, "divider finished outside a wait state")
   `SSE_CHECK_NOW(a_norm_range, rsp_valid, norm_in_range, "normalized speed above one")

endmodule

// File: tb/tb_smoothed_speed_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_speed_estimator
// self-checking bench for the windowed 3d speed meter
//
// a short table of hand-picked position words runs first, on the reset
// register values: the first word, zero-time steps, extreme coordinates,
// saturated speeds and a window that wraps. random motion follows over
// several register settings, out-of-range window lengths and a zero
// full-scale speed among them. a local model of the meter predicts the response
// words, bar table rows that carry their own, each checked field by field in arrival order. both
// handshakes stall at random, with one phase free of stalls.
// ----------------------------------------------------------------------------
module tb_smoothed_speed_estimator;

   localparam int METER_DEPTH  = sse_pkg::DEFAULT_MAX_WINDOW;
   localparam int IDLE_PERCENT = 28;
   localparam int NUM_PROBES   = 20;
   localparam int NUM_PHASES   = 8;
   localparam int SETTLE_CYCLES = 130;
   localparam int POS_W        = sse_pkg::POS_W;
   localparam int TIME_W       = sse_pkg::TIME_W;
   localparam int SPEED_W      = sse_pkg::SPEED_W;
   localparam int NORM_W       = sse_pkg::NORM_W;
   localparam int WLEN_W       = sse_pkg::WLEN_W;
   localparam int CSR_INDEX_W  = sse_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W   = sse_pkg::CSR_DATA_W;

   // one row of the directed table
   typedef struct {
      sse_pkg::req_type word;
      bit               typed;
      sse_pkg::rsp_type want;
   } probe_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   sse_pkg::req_type       req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   sse_pkg::rsp_type       rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = sse_pkg::REG_WINDOW_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // model state of the meter
   sse_pkg::req_type       last_pos;
   bit                     meter_primed;
   logic [SPEED_W-1:0]     speed_ring [METER_DEPTH];
   int unsigned            ring_slot;
   int unsigned            ring_fill;
   longint unsigned        speed_total;
   logic [WLEN_W-1:0]      window_reg;
   logic [SPEED_W-1:0]     full_scale_reg;

   sse_pkg::rsp_type       pending_speeds [$];
   sse_pkg::rsp_type       oldest_speed;
   bit                     quiet_mode = 1'b0;
   int                     mismatch_count = 0;
   int                     words_sent = 0;
   int                     speeds_checked = 0;
   int                     settings_applied = 0;

   smoothed_speed_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // hard stop if the meter hangs
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // floor of the square root, one result bit at a time
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 25; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // advance the meter model by one position word, return the expected response
   function automatic sse_pkg::rsp_type advance_meter(input sse_pkg::req_type w);
      longint signed    dx, dy, dz;
      longint unsigned  travel, raw, avg, norm;
      int unsigned      span;
      sse_pkg::rsp_type r;
      raw = 0;
      if (meter_primed) begin
         dx = longint'(w.pos_x) - longint'(last_pos.pos_x);
         dy = longint'(w.pos_y) - longint'(last_pos.pos_y);
         dz = longint'(w.pos_z) - longint'(last_pos.pos_z);
         travel = floor_root(longint'(dx * dx + dy * dy + dz * dz));
         if (travel == 0)
            raw = 0;
         else if (w.elapsed_us == 0)
            raw = 64'hFFFF_FFFF;
         else begin
            raw = travel * 1000000 / w.elapsed_us;
            if (raw > 64'hFFFF_FFFF) raw = 64'hFFFF_FFFF;
         end
      end
      last_pos = w;
      meter_primed = 1'b1;

      // effective window length, clamped to 1..depth
      span = window_reg;
      if (span < 1) span = 1;
      if (span > METER_DEPTH) span = METER_DEPTH;
      if (ring_slot >= span) ring_slot = 0;
      if (ring_fill < span)
         ring_fill++;
      else
         speed_total -= speed_ring[ring_slot];
      speed_ring[ring_slot] = raw[SPEED_W-1:0];
      speed_total += raw;
      ring_slot++;
      if (ring_slot >= span) ring_slot = 0;

      avg = speed_total / ring_fill;
      if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
      if (full_scale_reg == 0)
         norm = (avg != 0) ? 65536 : 0;
      else begin
         norm = (avg << 16) / full_scale_reg;
         if (norm > 65536) norm = 65536;
      end
      r.smooth_speed     = avg[SPEED_W-1:0];
      r.normalized_speed = norm[NORM_W-1:0];
      return r;
   endfunction

   // random next position: mostly plausible motion, some noise
   function automatic sse_pkg::req_type next_position();
      sse_pkg::req_type w;
      int unsigned      kind;
      int unsigned      k;
      int               d;
      w = last_pos;
      kind = $urandom_range(99);
      if (kind < 80) begin
         if (kind < 70) begin
            k = $urandom_range(12);
            d = int'($urandom_range(2 << k)) - (1 << k);
            w.pos_x = POS_W'(last_pos.pos_x + d);
            d = int'($urandom_range(2 << k)) - (1 << k);
            w.pos_y = POS_W'(last_pos.pos_y + d);
            d = int'($urandom_range(2 << k)) - (1 << k);
            w.pos_z = POS_W'(last_pos.pos_z + d);
         end
         case ($urandom_range(3))
            0:       w.elapsed_us = TIME_W'($urandom_range(100, 1));
            1:       w.elapsed_us = TIME_W'($urandom_range(40000, 8000));
            2:       w.elapsed_us = TIME_W'($urandom_range(1048575, 1));
            default: w.elapsed_us = (kind >= 70 && $urandom_range(1)) ? '0
                                    : TIME_W'($urandom_range(1048575, 1));
         endcase
      end else if (kind < 85) begin
         w.pos_x = POS_W'(last_pos.pos_x + int'($urandom_range(64)) - 32);
         w.pos_y = POS_W'(last_pos.pos_y + int'($urandom_range(64)) - 32);
         w.elapsed_us = '0;
      end else begin
         w.pos_x = POS_W'($urandom);
         w.pos_y = POS_W'($urandom);
         w.pos_z = POS_W'($urandom);
         w.elapsed_us = TIME_W'($urandom);
      end
      return w;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input sse_pkg::req_type w, input bit typed,
                            input sse_pkg::rsp_type want);
      sse_pkg::rsp_type predicted;
      while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predicted = advance_meter(w);
      pending_speeds.push_back(typed ? want : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // register write, always with the meter idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == sse_pkg::REG_WINDOW_LENGTH) begin
         window_reg  = value[WLEN_W-1:0];
         ring_slot   = 0;
         ring_fill   = 0;
         speed_total = 0;
      end else begin
         full_scale_reg = value;
      end
      @(negedge clock);
   endtask

   // wait until every expected response word has arrived
   task automatic drain_meter();
      req_valid <= 1'b0;
      while (pending_speeds.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // receiver stalls
   always @(negedge clock)
      rsp_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_speeds.size() == 0)
            report_mismatch($sformatf("unexpected response word %h", rsp_data));
         else begin
            oldest_speed = pending_speeds.pop_front();
            speeds_checked++;
            if (rsp_data.smooth_speed !== oldest_speed.smooth_speed)
               report_mismatch($sformatf("smooth_speed expected %0d, got %0d",
                  oldest_speed.smooth_speed, rsp_data.smooth_speed));
            if (rsp_data.normalized_speed !== oldest_speed.normalized_speed)
               report_mismatch($sformatf("normalized_speed expected %0d, got %0d",
                  oldest_speed.normalized_speed, rsp_data.normalized_speed));
         end
      end
   end

   // directed words on the reset register values
   probe_row_type probe_table [NUM_PROBES] = '{
      // first word after reset only records the position
      '{'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'h003E8}, 1'b1, '{32'd0, 17'd0}},
      // no motion in zero time
      '{'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'h00000}, 1'b1, '{32'd0, 17'd0}},
      // motion in zero time saturates
      '{'{24'h800000, 24'h800000, 24'h800000, 20'h00000}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 20'hFFFFF}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h000000, 24'h000000, 24'h000000, 20'h00001}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h000001, 24'h000000, 24'h000000, 20'h00001}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h000001, 24'h000000, 24'h000001, 20'hFFFFF}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'h00003}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h555555, 24'hAAAAAA, 24'h555555, 20'h55555}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 20'hAAAAA}, 1'b0, '{32'd0, 17'd0}},
      // window of ten is full from here, oldest samples leave
      '{'{24'h000100, 24'h000000, 24'h000000, 20'h04111}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h000100, 24'h000100, 24'h000000, 20'h08235}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h000100, 24'h000100, 24'h000100, 20'h80000}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h7FFFFF, 24'h000000, 24'h000000, 20'h00001}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h7FFFFF, 24'h000000, 24'h000000, 20'h00000}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h7FFFFF, 24'h000000, 24'h000000, 20'hF4240}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h000000, 24'h800000, 24'h000000, 20'hF4240}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'h123456, 24'hFEDCBA, 24'h0F0F0F, 20'h7FFFF}, 1'b0, '{32'd0, 17'd0}},
      '{'{24'hEDCBA9, 24'h012345, 24'hF0F0F0, 20'h00010}, 1'b0, '{32'd0, 17'd0}}
   };

   // register settings per random phase
   logic [CSR_DATA_W-1:0] phase_window [NUM_PHASES] = '{10, 1, 16, 0, 31, 3, 17, 8};
   logic [CSR_DATA_W-1:0] phase_scale  [NUM_PHASES] =
      '{256000, 1, 32'hFFFF_FFFF, 0, 1000, 0, 65536, 0};
   bit                    phase_new_window [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};
   int                    phase_words  [NUM_PHASES] = '{200, 150, 250, 150, 150, 150, 150, 300};

   initial begin
      last_pos       = '0;
      meter_primed   = 1'b0;
      ring_slot      = 0;
      ring_fill      = 0;
      speed_total    = 0;
      window_reg     = sse_pkg::WINDOW_LENGTH_RESET;
      full_scale_reg = sse_pkg::MAX_SPEED_RESET;
      foreach (speed_ring[i]) speed_ring[i] = '0;

      // settings with random content
      phase_scale[5]  = $urandom;
      phase_window[7] = $urandom_range(16, 1);
      phase_scale[7]  = $urandom_range(2000000, 1);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (probe_table[i])
         send_word(probe_table[i].word, probe_table[i].typed, probe_table[i].want);

      // random phases
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_meter();
         if (phase_new_window[p])
            write_csr(sse_pkg::REG_WINDOW_LENGTH, phase_window[p]);
         write_csr(sse_pkg::REG_MAX_SPEED, phase_scale[p]);
         settings_applied++;
         quiet_mode = (p == 2);
         for (int n = 0; n < phase_words[p]; n++)
            send_word(next_position(), 1'b0, '0);
      end
      quiet_mode = 1'b0;

      // wrap up
      drain_meter();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_speeds.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived",
            pending_speeds.size()));
      $display("run covered %0d position words (%0d directed) over %0d register settings",
         words_sent, NUM_PROBES, settings_applied);
      $display("%0d response words compared, %0d mismatches",
         speeds_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/sse_pkg.sv
hdl/sse_sqrt.sv
hdl/sse_div.sv
hdl/smoothed_speed_estimator.sv
tb/tb_smoothed_speed_estimator.sv
